>>> hw/rtl/mal_pkg.sv
`default_nettype none

package mal_pkg;

   // default angle scaling of the latitude fields
   localparam int ANGLE_FRAC_BITS_DEF = 29;

   // multiplier unit latency in cycles
   localparam int MUL_LAT = 5;

   // cordic word widths and iteration count
   localparam int CORDIC_ITERS = 32;
   localparam int CORDIC_XW    = 33;
   localparam int CORDIC_ZW    = 35;

   // angle constants, radians with 32 fraction bits
   localparam logic [33:0] PI_Q32      = 34'd13493037705;
   localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;

   // cordic start value, 30 fraction bits
   localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

   // series constants with 58 fraction bits
   localparam logic signed [63:0] Q58_ONE   = 64'sd1 <<< 58;
   localparam logic signed [63:0] Q58_1P25  = 64'sd5 <<< 56;
   localparam logic signed [63:0] Q58_2P625 = 64'sd21 <<< 55;
   localparam logic signed [63:0] Q58_1P875 = 64'sd15 <<< 55;
   localparam logic signed [63:0] Q58_THREE = 64'sd3 <<< 58;
   localparam logic signed [63:0] Q58_35_24 = (64'sd35 <<< 55) / 64'sd3;

   // result saturation limits
   localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< 40) - 64'sd1;
   localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< 40);

   // ratio division steps
   localparam int DIV_STEPS = 59;

   // csr register indexes
   localparam logic [1:0] CSR_SEMI_MAJOR = 2'd0;
   localparam logic [1:0] CSR_SEMI_MINOR = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_LAT = 2'd2;
   localparam logic [1:0] CSR_SCALE      = 2'd3;

   // stage control that travels into the pipelined units
   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

   // coefficient sequencer states
   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_RATIO = 7'b0000100,
      ST_ISSUE = 7'b0001000,
      ST_WAIT  = 7'b0010000,
      ST_SUM   = 7'b0100000,
      ST_READY = 7'b1000000
   } coef_state_type;

   // coefficient product steps
   typedef enum logic [3:0] {
      SP_N2 = 4'd0,
      SP_N3 = 4'd1,
      SP_A1 = 4'd2,
      SP_A2 = 4'd3,
      SP_B1 = 4'd4,
      SP_B2 = 4'd5,
      SP_B3 = 4'd6,
      SP_C1 = 4'd7,
      SP_C2 = 4'd8,
      SP_D1 = 4'd9
   } coef_step_type;

   localparam int COEF_STEPS = 10;

   // arctangent of 2^-i, 32 fraction bits, rounded
   function automatic logic [CORDIC_ZW-1:0] atan_q32(input int i);
      logic [CORDIC_ZW-1:0] t;
      case (i)
         0:  t = 35'd3373259426;
         1:  t = 35'd1991351318;
         2:  t = 35'd1052175346;
         3:  t = 35'd534100635;
         4:  t = 35'd268086748;
         5:  t = 35'd134174063;
         6:  t = 35'd67103403;
         7:  t = 35'd33553749;
         8:  t = 35'd16777131;
         9:  t = 35'd8388597;
         10: t = 35'd4194303;
         default: t = CORDIC_ZW'(1) << (32 - i);
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/meridional_arc_length.sv
`default_nettype none

// Meridional arc length: for each latitude beat (radians times
// 2^ANGLE_FRAC_BITS) the block returns the scaled meridional arc in
// millimetres from the configured origin latitude, using the third-order
// series in n = (a-b)/(a+b), saturated to 41 bits. One latitude is taken
// every clock cycle while the coefficients are ready and the result side
// does not stall; a beat passes the input register, the reduction and
// 32-stage cordic in each of the six sine/cosine lanes, three five-stage
// multiplier rounds, the bracket sum register and the output register.
// A stall on the result side halts the whole pipeline without loss.
// After reset, and after every write of the semi-major axis, semi-minor
// axis or scale factor, req_tready stays low while the series
// coefficients are recomputed by a serial divider and one shared
// multiplier; a write of the origin latitude takes effect at once.
// Registers are to be written only while no beat is in flight.
module meridional_arc_length import mal_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // latitude [30:0]
   input  logic [31:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // arc_distance [40:0]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [32:0] csr_data
);

   localparam int LAT_SC = 69 - ANGLE_FRAC_BITS;
   localparam int DL     = LAT_SC + MUL_LAT;

   // configuration registers
   logic [32:0] semi_major_ff;
   logic [32:0] semi_minor_ff;
   logic [30:0] origin_ff;
   logic [31:0] scale_ff;

   // coefficient sequencer
   coef_state_type     state_ff, state_in;
   coef_step_type      step_ff;
   logic [5:0]         cnt_ff;
   logic [35:0]        rem_ff, rem2;
   logic [58:0]        q_ff;
   logic [33:0]        den, num;
   logic [58:0]        nmag;
   logic signed [63:0] n_ff;
   logic signed [63:0] prod_ff [0:COEF_STEPS-1];
   logic signed [63:0] c_ff [0:3];
   logic signed [63:0] bk_ff;
   logic signed [63:0] opa, opb, cmul_p, bk_p;
   logic               cmul_valid, bk_valid;
   pipe_ctl_type       ctl_coef, ctl_bk;
   logic               axis_write;

   // item pipeline
   logic               pipe_en;
   logic               v1_ff;
   logic signed [31:0] d_in, s_in, d_ff;
   logic signed [33:0] ang_ff [0:5];
   logic signed [31:0] dly_ff [0:DL-1];
   logic signed [31:0] sd [0:2];
   logic signed [31:0] cs [0:2];
   logic               lane_valid;
   logic signed [63:0] pr [0:2];
   logic               pr_valid;
   logic signed [63:0] tm [0:2];
   logic signed [63:0] m0;
   logic               t_valid;
   logic signed [63:0] m_ff;
   logic               vm_ff;
   logic signed [63:0] res;
   logic               res_valid;
   logic               rsp_valid_ff;
   logic [40:0]        rsp_data_ff;
   pipe_ctl_type       ctl_lane, ctl_p, ctl_t, ctl_f;

   assign csr_ready  = 1'b1;
   assign axis_write = csr_valid && csr_ready && (csr_index != CSR_ORIGIN_LAT);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         semi_major_ff <= 33'd6378137000;
         semi_minor_ff <= 33'd6356752314;
         origin_ff     <= '0;
         scale_ff      <= 32'd1073741824;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEMI_MAJOR: semi_major_ff <= csr_data;
            CSR_SEMI_MINOR: semi_minor_ff <= csr_data;
            CSR_ORIGIN_LAT: origin_ff     <= csr_data[30:0];
            CSR_SCALE:      scale_ff      <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // ratio operands
   assign den  = 34'(semi_major_ff) + 34'(semi_minor_ff);
   assign num  = (semi_major_ff >= semi_minor_ff) ? 34'(semi_major_ff - semi_minor_ff)
                                                  : 34'(semi_minor_ff - semi_major_ff);
   assign rem2 = {rem_ff[34:0], 1'b0};
   assign nmag = (num >= den) ? (59'd1 << 58) : 59'((60'(q_ff) + 60'd1) >> 1);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_RATIO;
         ST_RATIO: state_in = ST_ISSUE;
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (cmul_valid) state_in = (step_ff == SP_D1) ? ST_SUM : ST_ISSUE;
         end
         ST_SUM:   state_in = ST_READY;
         ST_READY: state_in = ST_READY;
         default:  state_in = ST_LOAD;
      endcase
      if (axis_write) state_in = ST_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // divider, product steps and coefficient sums
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            rem_ff  <= 36'(num);
            q_ff    <= '0;
            cnt_ff  <= '0;
            step_ff <= SP_N2;
         end
         ST_DIV: begin
            cnt_ff <= cnt_ff + 6'd1;
            if (rem2 >= 36'(den)) begin
               rem_ff <= rem2 - 36'(den);
               q_ff   <= {q_ff[57:0], 1'b1};
            end else begin
               rem_ff <= rem2;
               q_ff   <= {q_ff[57:0], 1'b0};
            end
         end
         ST_RATIO: begin
            if (den == '0) begin
               n_ff <= '0;
            end else if (semi_major_ff >= semi_minor_ff) begin
               n_ff <= $signed(64'(nmag));
            end else begin
               n_ff <= $signed(64'd0 - 64'(nmag));
            end
         end
         ST_WAIT: begin
            if (cmul_valid) begin
               prod_ff[step_ff] <= cmul_p;
               if (step_ff != SP_D1) step_ff <= coef_step_type'(step_ff + 4'd1);
            end
         end
         ST_SUM: begin
            c_ff[0] <= Q58_ONE + n_ff + prod_ff[SP_A1] + prod_ff[SP_A2];
            c_ff[1] <= prod_ff[SP_B1] + prod_ff[SP_B2] + prod_ff[SP_B3];
            c_ff[2] <= prod_ff[SP_C1] + prod_ff[SP_C2];
            c_ff[3] <= prod_ff[SP_D1];
         end
         default: ;
      endcase
      if (bk_valid) bk_ff <= bk_p;
   end

   // operands of the shared multiplier
   always_comb begin
      case (step_ff)
         SP_N2:   begin opa = n_ff;      opb = n_ff;            end
         SP_N3:   begin opa = n_ff;      opb = prod_ff[SP_N2];  end
         SP_A1:   begin opa = Q58_1P25;  opb = prod_ff[SP_N2];  end
         SP_A2:   begin opa = Q58_1P25;  opb = prod_ff[SP_N3];  end
         SP_B1:   begin opa = Q58_THREE; opb = n_ff;            end
         SP_B2:   begin opa = Q58_THREE; opb = prod_ff[SP_N2];  end
         SP_B3:   begin opa = Q58_2P625; opb = prod_ff[SP_N3];  end
         SP_C1:   begin opa = Q58_1P875; opb = prod_ff[SP_N2];  end
         SP_C2:   begin opa = Q58_1P875; opb = prod_ff[SP_N3];  end
         SP_D1:   begin opa = Q58_35_24; opb = prod_ff[SP_N3];  end
         default: begin opa = '0;        opb = '0;              end
      endcase
   end

   assign ctl_coef.en    = 1'b1;
   assign ctl_coef.valid = (state_ff == ST_ISSUE);
   assign ctl_bk.en      = 1'b1;
   assign ctl_bk.valid   = (state_ff == ST_ISSUE) && (step_ff == SP_N2);

   mal_mul #(.WA(64), .WB(64), .SHIFT(58)) u_coef_mul (
      .clock(clock), .reset(reset), .ctl(ctl_coef),
      .a(opa), .b(opb), .out_valid(cmul_valid), .p(cmul_p)
   );

   // k*b with 20 fraction bits
   mal_mul #(.WA(34), .WB(33), .SHIFT(10)) u_bk_mul (
      .clock(clock), .reset(reset), .ctl(ctl_bk),
      .a($signed({1'b0, semi_minor_ff})), .b($signed({1'b0, scale_ff})),
      .out_valid(bk_valid), .p(bk_p)
   );

   // pipeline advances unless the output register holds a stalled beat
   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en && (state_ff == ST_READY);

   // difference and sum with the origin, and their multiples
   assign d_in = $signed({req_tdata[30], req_tdata[30:0]}) - $signed({origin_ff[30], origin_ff});
   assign s_in = $signed({req_tdata[30], req_tdata[30:0]}) + $signed({origin_ff[30], origin_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         d_ff <= d_in;
         for (int j = 0; j < 3; j++) begin
            ang_ff[j]   <= 34'(d_in) * 34'(j + 1);
            ang_ff[3+j] <= 34'(s_in) * 34'(j + 1);
         end
      end
   end

   // angle difference waits for the sine/cosine lanes and first products
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dly_ff[0] <= d_ff;
         for (int k = 1; k < DL; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   assign ctl_lane.en    = pipe_en;
   assign ctl_lane.valid = v1_ff;
   assign ctl_p.en       = pipe_en;
   assign ctl_p.valid    = lane_valid;
   assign ctl_t.en       = pipe_en;
   assign ctl_t.valid    = pr_valid;
   assign ctl_f.en       = pipe_en;
   assign ctl_f.valid    = vm_ff;

   // sin(j*d) cos(j*s) for j = 1..3
   for (genvar j = 0; j < 3; j++) begin : g_lane
      logic vd;
      logic pv;
      mal_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_d (
         .clock(clock), .reset(reset), .ctl(ctl_lane), .angle(ang_ff[j]),
         .out_valid(vd), .sin_out(sd[j]), .cos_out()
      );
      mal_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_s (
         .clock(clock), .reset(reset), .ctl(ctl_lane), .angle(ang_ff[3+j]),
         .out_valid(), .sin_out(), .cos_out(cs[j])
      );
      mal_mul #(.WA(32), .WB(32), .SHIFT(30)) u_sc_mul (
         .clock(clock), .reset(reset), .ctl(ctl_p),
         .a(sd[j]), .b(cs[j]), .out_valid(pv), .p(pr[j])
      );
      mal_mul #(.WA(64), .WB(64), .SHIFT(48)) u_term_mul (
         .clock(clock), .reset(reset), .ctl(ctl_t),
         .a(c_ff[j+1]), .b(pr[j]), .out_valid(), .p(tm[j])
      );
      if (j == 0) begin : g_vld
         assign lane_valid = vd;
         assign pr_valid   = pv;
      end
   end

   // leading term straight from the angle units
   mal_mul #(.WA(64), .WB(32), .SHIFT(18 + ANGLE_FRAC_BITS)) u_lead_mul (
      .clock(clock), .reset(reset), .ctl(ctl_t),
      .a(c_ff[0]), .b(dly_ff[DL-1]), .out_valid(t_valid), .p(m0)
   );

   // bracket sum
   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (pipe_en) begin
         vm_ff <= t_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m_ff <= m0 - tm[0] + tm[1] - tm[2];
      end
   end

   // scale by k*b and round to millimetres
   mal_mul #(.WA(64), .WB(64), .SHIFT(60)) u_final_mul (
      .clock(clock), .reset(reset), .ctl(ctl_f),
      .a(m_ff), .b(bk_ff), .out_valid(res_valid), .p(res)
   );

   // saturation and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         if (res > OUT_MAX) begin
            rsp_data_ff <= OUT_MAX[40:0];
         end else if (res < OUT_MIN) begin
            rsp_data_ff <= OUT_MIN[40:0];
         end else begin
            rsp_data_ff <= res[40:0];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule

`default_nettype wire

>>> hw/rtl/mal_mul.sv
`default_nettype none

// signed product, rounded half away from zero after a right shift,
// magnitude clamped to 2^63-1, split into four partial products
module mal_mul import mal_pkg::*; #(
   parameter int WA    = 64,
   parameter int WB    = 64,
   parameter int SHIFT = 58
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         ctl,
   input  logic signed [WA-1:0] a,
   input  logic signed [WB-1:0] b,
   output logic                 out_valid,
   output logic signed [63:0]   p
);

   localparam int HA = (WA + 1) / 2;
   localparam int HB = (WB + 1) / 2;
   localparam int PW = WA + WB;
   localparam int CW = (PW + 1 > 64) ? PW + 1 : 64;
   localparam logic [CW-1:0] RND    = CW'(1) << (SHIFT - 1);
   localparam logic [CW-1:0] MAG_MAX = CW'(64'h7FFF_FFFF_FFFF_FFFF);

   logic [4:0]           vld_ff;
   logic [WA-1:0]        ua_ff, ua_in;
   logic [WB-1:0]        ub_ff, ub_in;
   logic [3:0]           neg_ff;
   logic [HA+HB-1:0]     pp00_ff;
   logic [HA+WB-HB-1:0]  pp01_ff;
   logic [WA-HA+HB-1:0]  pp10_ff;
   logic [PW-HA-HB-1:0]  pp11_ff;
   logic [CW-1:0]        lo_ff, hi_ff, sum_ff;
   logic [CW-1:0]        mag_full;
   logic [63:0]          mag64;
   logic signed [63:0]   p_ff;

   // magnitudes of the operands
   assign ua_in = a[WA-1] ? (~a + WA'(1)) : a;
   assign ub_in = b[WB-1] ? (~b + WB'(1)) : b;

   // clamp and sign of the shifted sum
   assign mag_full = sum_ff >> SHIFT;
   assign mag64    = (mag_full > MAG_MAX) ? 64'h7FFF_FFFF_FFFF_FFFF : mag_full[63:0];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.en) begin
         vld_ff <= {vld_ff[3:0], ctl.valid};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         neg_ff  <= {neg_ff[2:0], a[WA-1] ^ b[WB-1]};
         pp00_ff <= (HA+HB)'(ua_ff[HA-1:0]) * (HA+HB)'(ub_ff[HB-1:0]);
         pp01_ff <= (HA+WB-HB)'(ua_ff[HA-1:0]) * (HA+WB-HB)'(ub_ff[WB-1:HB]);
         pp10_ff <= (WA-HA+HB)'(ua_ff[WA-1:HA]) * (WA-HA+HB)'(ub_ff[HB-1:0]);
         pp11_ff <= (PW-HA-HB)'(ua_ff[WA-1:HA]) * (PW-HA-HB)'(ub_ff[WB-1:HB]);
         lo_ff   <= CW'(pp00_ff) + (CW'(pp01_ff) << HB) + RND;
         hi_ff   <= (CW'(pp10_ff) << HA) + (CW'(pp11_ff) << (HA + HB));
         sum_ff  <= lo_ff + hi_ff;
         p_ff    <= neg_ff[3] ? $signed(64'd0 - mag64) : $signed(mag64);
      end
   end

   assign out_valid = vld_ff[4];
   assign p         = p_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mal_sincos.sv
`default_nettype none

// angle reduction by pi, one quotient bit a stage, then a 32-stage
// rotation cordic; sin and cos come out with 30 fraction bits
module mal_sincos import mal_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  pipe_ctl_type       ctl,
   input  logic signed [33:0] angle,
   output logic               out_valid,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);

   localparam int QB  = 34 - ANGLE_FRAC_BITS;
   localparam int RW  = 67 - ANGLE_FRAC_BITS;
   localparam int SH  = 32 - ANGLE_FRAC_BITS;
   localparam int KSH = 33 - ANGLE_FRAC_BITS;
   localparam int NV  = QB + 35;
   localparam int XW  = CORDIC_XW;
   localparam int ZW  = CORDIC_ZW;
   localparam logic [RW-1:0] OFFSET = (RW'(PI_Q32) << KSH) + RW'(HALF_PI_Q32);

   logic [NV-1:0]                vld_ff;
   logic [RW-1:0]                r_ff [0:QB];
   logic                         par_ff;
   logic signed [XW-1:0]         x_ff [0:CORDIC_ITERS];
   logic signed [XW-1:0]         y_ff [0:CORDIC_ITERS];
   logic signed [ZW-1:0]         z_ff [0:CORDIC_ITERS];
   logic                         pz_ff [0:CORDIC_ITERS];
   logic signed [31:0]           sin_ff, cos_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.en) begin
         vld_ff <= {vld_ff[NV-2:0], ctl.valid};
      end
   end

   // scale to 32 fraction bits and bias by half pi plus a multiple of pi
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         r_ff[0] <= ({{(RW-34){angle[33]}}, angle} << SH) + OFFSET;
      end
   end

   // restoring division by pi, most significant quotient bit first
   for (genvar k = 0; k < QB; k++) begin : g_red
      localparam logic [RW-1:0] DIVISOR = RW'(PI_Q32) << (QB - 1 - k);
      logic ge;
      assign ge = (r_ff[k] >= DIVISOR);
      always_ff @(posedge clock) begin
         if (ctl.en) begin
            r_ff[k+1] <= ge ? (r_ff[k] - DIVISOR) : r_ff[k];
         end
      end
      if (k == QB - 1) begin : g_par
         always_ff @(posedge clock) begin
            if (ctl.en) begin
               par_ff <= ge;
            end
         end
      end
   end

   // remainder back to an angle in [-pi/2, pi/2)
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         x_ff[0]  <= CORDIC_GAIN_Q30;
         y_ff[0]  <= '0;
         z_ff[0]  <= $signed({1'b0, r_ff[QB][33:0]}) - $signed({2'b00, HALF_PI_Q32});
         pz_ff[0] <= par_ff;
      end
   end

   // cordic rotations
   for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_rot
      localparam logic signed [ZW-1:0] T = $signed(atan_q32(k));
      logic signed [XW-1:0] dx, dy;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (ctl.en) begin
            pz_ff[k+1] <= pz_ff[k];
            if (!z_ff[k][ZW-1]) begin
               x_ff[k+1] <= x_ff[k] - dx;
               y_ff[k+1] <= y_ff[k] + dy;
               z_ff[k+1] <= z_ff[k] - T;
            end else begin
               x_ff[k+1] <= x_ff[k] + dx;
               y_ff[k+1] <= y_ff[k] - dy;
               z_ff[k+1] <= z_ff[k] + T;
            end
         end
      end
   end

   // odd multiples of pi flip both signs
   always_ff @(posedge clock) begin
      if (ctl.en) begin
         if (pz_ff[CORDIC_ITERS]) begin
            sin_ff <= 32'(-y_ff[CORDIC_ITERS]);
            cos_ff <= 32'(-x_ff[CORDIC_ITERS]);
         end else begin
            sin_ff <= 32'(y_ff[CORDIC_ITERS]);
            cos_ff <= 32'(x_ff[CORDIC_ITERS]);
         end
      end
   end

   assign out_valid = vld_ff[NV-1];
   assign sin_out   = sin_ff;
   assign cos_out   = cos_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mal_check.sv
`default_nettype none

module mal_check import mal_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic [31:0] req_tdata,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [32:0] csr_data
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // padding above the arc field stays zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:41] == 7'd0)
      else $error("result padding not zero");

   // axis or scale write blocks input while coefficients are rebuilt
   a_coef_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index != CSR_ORIGIN_LAT |=> !req_tready)
      else $error("input taken during coefficient update");

endmodule

bind meridional_arc_length mal_check u_check (.*);

`default_nettype wire
